/* design/sptf_pkg.sv */
// ----------------------------------------------------------------------------
// sptf_pkg: shared types and constants of the sorted token prefix filter
// Opcodes of the request channel, field widths and the query entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sptf_pkg;

    // field widths fixed by the request and result formats
    localparam int OPCODE_W = 2;
    localparam int ENTRY_W  = 6;
    localparam int TOKEN_W  = 16;
    localparam int QLEN_W   = 7;
    localparam int CNT_W    = 24;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_TOKEN = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_END   = 2'd2;

    // one query position: expected token and divergence interval
    typedef struct packed {
        logic [TOKEN_W-1:0] token;
        logic [TOKEN_W-1:0] low;
        logic [TOKEN_W-1:0] high;
    } query_entry_t;

endpackage

`default_nettype wire

/* design/sptf_query_mem.sv */
// ----------------------------------------------------------------------------
// sptf_query_mem: query entry memory
// One write port and one registered read port; a write to the address being
// read in the same cycle is forwarded to the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sptf_query_mem
    import sptf_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire query_entry_t      wr_entry,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output query_entry_t           rd_entry
);

    query_entry_t mem_reg [DEPTH];
    query_entry_t rd_entry_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_entry;
        end
    end

    // read port with write forwarding
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_entry_reg <= wr_entry;
        end else begin
            rd_entry_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

`default_nettype wire

/* design/sorted_token_prefix_filter.sv */
// ----------------------------------------------------------------------------
// sorted_token_prefix_filter: prefix query filter over token-coded documents
// Loads a tokenized query with per-position divergence intervals, then
// decides for every streamed document whether it begins with the query.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (s_*): opcode 0 loads a query entry, opcode 1 carries a
//   document token (s_doc_last on the final one), opcode 2 ends an empty or
//   open document, opcode 3 is dropped. Result channel (m_*): one result per
//   document end with its index, match flag and running match count.
//   cfg_wr_en/cfg_wr_data set the query length; write it only while idle.
// Timing:
//   A request is evaluated while it sits in the input register, against the
//   query entry at the current document position, read from the entry
//   memory ahead at the next position. Its result is valid the cycle after
//   the request is taken; one request every cycle but for a held document end.
// Reset and stall:
//   aresetn (synchronous, active low) clears position, verdict, counters and
//   query length; the entry memory keeps its contents. While m_ready is low
//   and a result waits, a request that ends a document holds in the input
//   register and s_ready drops; other requests keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_token_prefix_filter
    import sptf_pkg::*;
#(
    parameter int MAX_QUERY_TOKENS = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic [QLEN_W-1:0]   cfg_wr_data,
    // request channel
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [OPCODE_W-1:0] s_opcode,
    input  wire logic [ENTRY_W-1:0]  s_entry_index,
    input  wire logic [TOKEN_W-1:0]  s_token_id,
    input  wire logic [TOKEN_W-1:0]  s_interval_low,
    input  wire logic [TOKEN_W-1:0]  s_interval_high,
    input  wire logic                s_doc_last,
    // result channel
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [CNT_W-1:0]         m_document_index,
    output logic                     m_is_match,
    output logic [CNT_W-1:0]         m_matches_so_far
);

    localparam int ADDR_W = (MAX_QUERY_TOKENS > 1) ? $clog2(MAX_QUERY_TOKENS) : 1;
    localparam int POS_W  = $clog2(MAX_QUERY_TOKENS + 1);
    localparam int CMP_W  = (POS_W > QLEN_W) ? POS_W : QLEN_W;
    localparam int WIDE_W = ((ADDR_W > ENTRY_W) ? ADDR_W : ENTRY_W) + 1;

    // configuration register
    logic [QLEN_W-1:0] query_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_length_reg <= '0;
        end else if (cfg_wr_en) begin
            query_length_reg <= cfg_wr_data;
        end
    end

    // input register
    logic                in_valid_reg;
    logic [OPCODE_W-1:0] in_opcode_reg;
    logic [ENTRY_W-1:0]  in_index_reg;
    logic [TOKEN_W-1:0]  in_token_reg;
    logic [TOKEN_W-1:0]  in_low_reg;
    logic [TOKEN_W-1:0]  in_high_reg;
    logic                in_last_reg;

    logic out_valid_reg;
    logic in_finish;
    logic fire;

    assign in_finish = (in_opcode_reg == OP_END) ||
                       ((in_opcode_reg == OP_TOKEN) && in_last_reg);
    assign fire      = in_valid_reg && (!in_finish || !out_valid_reg || m_ready);
    assign s_ready   = aresetn && (!in_valid_reg || fire);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_opcode_reg <= s_opcode;
            in_index_reg  <= s_entry_index;
            in_token_reg  <= s_token_id;
            in_low_reg    <= s_interval_low;
            in_high_reg   <= s_interval_high;
            in_last_reg   <= s_doc_last;
        end
    end

    // document state
    logic [POS_W-1:0] doc_position_reg;
    logic [POS_W-1:0] doc_position_next;
    logic             verdict_known_reg;
    logic             verdict_known_next;
    logic             verdict_value_reg;
    logic             verdict_value_next;
    logic [CNT_W-1:0] document_counter_reg;
    logic [CNT_W-1:0] match_counter_reg;
    logic [CNT_W-1:0] match_counter_next;

    // query entry memory, read ahead at the next position
    logic              load_ok;
    logic              mem_wr_en;
    logic [WIDE_W-1:0] entry_wide;
    query_entry_t      wr_entry;
    query_entry_t      cur_entry;

    assign entry_wide = WIDE_W'(in_index_reg);
    assign load_ok    = entry_wide < WIDE_W'(MAX_QUERY_TOKENS);
    assign mem_wr_en  = fire && (in_opcode_reg == OP_LOAD) && load_ok;
    assign wr_entry   = '{token: in_token_reg, low: in_low_reg, high: in_high_reg};

    sptf_query_mem #(
        .DEPTH  (MAX_QUERY_TOKENS),
        .ADDR_W (ADDR_W)
    ) u_query_mem (
        .aclk     (aclk),
        .wr_en    (mem_wr_en),
        .wr_addr  (entry_wide[ADDR_W-1:0]),
        .wr_entry (wr_entry),
        .rd_addr  (doc_position_next[ADDR_W-1:0]),
        .rd_entry (cur_entry)
    );

    // effective query length and position compare
    logic [CMP_W-1:0]   qlen_ext;
    logic [CMP_W-1:0]   max_ext;
    logic [CMP_W-1:0]   eff_len;
    logic [CMP_W-1:0]   pos_ext;
    logic [TOKEN_W-1:0] offset;
    logic [TOKEN_W-1:0] span;
    logic               step_pos_ok;
    logic               done_match;

    assign qlen_ext = CMP_W'(query_length_reg);
    assign max_ext  = CMP_W'(MAX_QUERY_TOKENS);
    assign eff_len  = (qlen_ext > max_ext) ? max_ext : qlen_ext;
    assign pos_ext  = CMP_W'(doc_position_reg);
    assign offset   = in_token_reg - cur_entry.low;
    assign span     = cur_entry.high - cur_entry.low;

    // one token step, then an optional document end
    always_comb begin
        doc_position_next  = doc_position_reg;
        verdict_known_next = verdict_known_reg;
        verdict_value_next = verdict_value_reg;
        match_counter_next = match_counter_reg;
        step_pos_ok        = 1'b0;
        done_match         = 1'b0;
        if (fire && (in_opcode_reg == OP_TOKEN) && !verdict_known_reg) begin
            if ((pos_ext >= eff_len) || (pos_ext >= max_ext)) begin
                verdict_known_next = 1'b1;
                verdict_value_next = 1'b1;
            end else if (in_token_reg == cur_entry.token) begin
                doc_position_next = doc_position_reg + POS_W'(1);
            end else begin
                verdict_known_next = 1'b1;
                verdict_value_next = offset < span;
            end
        end
        step_pos_ok = CMP_W'(doc_position_next) >= eff_len;
        if (fire && in_finish) begin
            done_match         = verdict_known_next ? verdict_value_next : step_pos_ok;
            match_counter_next = match_counter_reg + CNT_W'(done_match);
            doc_position_next  = '0;
            verdict_known_next = 1'b0;
            verdict_value_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            doc_position_reg     <= '0;
            verdict_known_reg    <= 1'b0;
            verdict_value_reg    <= 1'b0;
            document_counter_reg <= '0;
            match_counter_reg    <= '0;
        end else begin
            doc_position_reg  <= doc_position_next;
            verdict_known_reg <= verdict_known_next;
            verdict_value_reg <= verdict_value_next;
            match_counter_reg <= match_counter_next;
            if (fire && in_finish) begin
                document_counter_reg <= document_counter_reg + CNT_W'(1);
            end
        end
    end

    // result register
    logic [CNT_W-1:0] out_index_reg;
    logic             out_match_reg;
    logic [CNT_W-1:0] out_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire && in_finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && in_finish) begin
            out_index_reg <= document_counter_reg;
            out_match_reg <= done_match;
            out_count_reg <= match_counter_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_document_index = out_index_reg;
    assign m_is_match       = out_match_reg;
    assign m_matches_so_far = out_count_reg;

    // position never runs past the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        doc_position_reg <= POS_W'(MAX_QUERY_TOKENS))
        else $error("document position beyond query table");

    // a document end clears the per-document state
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_finish) |=> (doc_position_reg == '0) && !verdict_known_reg)
        else $error("document state not cleared at document end");

    // a new result carries the counters it was built from
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_finish) |=> (m_matches_so_far == match_counter_reg) &&
            (m_document_index + CNT_W'(1) == document_counter_reg))
        else $error("result counters out of step with state");

    // a result only appears after a document end was evaluated
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(fire && in_finish))
        else $error("result without document end");

    // a stalled request channel means the input register is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && in_finish && out_valid_reg && !m_ready))
        else $error("request channel stalled without cause");

endmodule

`default_nettype wire
